@@ rtl/rgbhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rgbhsv_pkg;

	// Width of every pixel channel and of every result field.
	localparam int CH_W = 16;

	// Width of the hue numerator and denominator (up to six times the chroma).
	localparam int HX_W = CH_W + 3;

	localparam int FRACTION_BITS_DEF = 15;
	localparam int QUEUE_DEPTH_DEF = 4;

	// One classified pixel, handed from the front end to the divider pipeline.
	typedef struct packed {
		logic            gray;    // chroma is zero
		logic            neg;     // hue numerator is negative
		logic [CH_W-1:0] vmax;    // value, also the saturation divisor
		logic [CH_W-1:0] chroma;  // saturation dividend
		logic [HX_W-1:0] hnum;    // magnitude of the hue numerator
		logic [HX_W-1:0] hden;    // six times the chroma
	} item_t;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsv_converter.sv @@
// RGB to HSV converter, one pixel beat in and one HSV beat out.
// Each accepted beat passes the front-end register, the queue, the divider stages and the output register.
// Throughput: one beat per cycle while hsv_stall is low; the divider pipeline gives one quotient bit a stage.
// Reset (arst_n low, asynchronous) empties the queue and clears all valid flags.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_queue and rgbhsv_back.
`default_nettype none

module rgb_to_hsv_converter #(
	parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF,
	parameter int QUEUE_DEPTH   = rgbhsv_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          pix_valid,
	output logic                         pix_stall,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  red,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  green,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  blue,
	output logic                         hsv_valid,
	input  wire                          hsv_stall,
	output logic [rgbhsv_pkg::CH_W-1:0]  hue,
	output logic [rgbhsv_pkg::CH_W-1:0]  saturation,
	output logic [rgbhsv_pkg::CH_W-1:0]  brightness
);
	import rgbhsv_pkg::*;

	// The front end registers each accepted beat after clamping the channels
	// and working out value, chroma and the hue sector. The hue numerator is
	// kept as a magnitude with a sign flag; only the red sector can be
	// negative, when green is below blue.
	//
	// A short queue separates it from the back end, so a stalled output only
	// reaches pix_stall once the queue has filled up.
	//
	// The back end runs two restoring dividers side by side, saturation as
	// chroma over value and hue as numerator over six times chroma, one
	// quotient bit per stage. The last step folds negative hue back into the
	// turn and forces gray pixels to zero hue and saturation.

	logic  push, pop, q_full, q_empty;
	item_t front_item, head_item;

	rgbhsv_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_full    (q_full),
		.push      (push),
		.item      (front_item)
	);

	rgbhsv_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.head    (head_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	rgbhsv_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head_item),
		.pop        (pop),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule

`default_nettype wire

@@ rtl/rgbhsv_front.sv @@
// Front end of the RGB to HSV converter: accepts pixels, clamps channels,
// finds value, chroma, hue sector and divider operands. Uses rgbhsv_pkg.
`default_nettype none

module rgbhsv_front #(
	parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          pix_valid,
	output logic                         pix_stall,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  red,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  green,
	input  wire  [rgbhsv_pkg::CH_W-1:0]  blue,
	input  wire                          q_full,
	output logic                         push,
	output rgbhsv_pkg::item_t            item
);
	import rgbhsv_pkg::*;

	localparam int EW = (FRACTION_BITS + 1 > CH_W) ? FRACTION_BITS + 1 : CH_W;
	localparam logic [EW-1:0] ONE_E = EW'(1) << FRACTION_BITS;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	function automatic logic [CH_W-1:0] clamp(input logic [CH_W-1:0] v);
		logic [EW-1:0] ve;
		ve = EW'(v);
		return (ve > ONE_E) ? CH_W'(ONE_E) : v;
	endfunction

	logic [CH_W-1:0] r, g, b, vmax, vmin, chroma;
	sector_t         sector;
	item_t           item_d;
	item_t           item_s1;
	logic            valid_s1;

	always_comb begin
		r = clamp(red);
		g = clamp(green);
		b = clamp(blue);

		vmax = r;
		if (g > vmax) begin
			vmax = g;
		end
		if (b > vmax) begin
			vmax = b;
		end
		vmin = r;
		if (g < vmin) begin
			vmin = g;
		end
		if (b < vmin) begin
			vmin = b;
		end
		chroma = vmax - vmin;

		// Red wins a tie with green, green wins a tie with blue.
		priority if (vmax == r) begin
			sector = SEC_RED;
		end else if (vmax == g) begin
			sector = SEC_GREEN;
		end else begin
			sector = SEC_BLUE;
		end

		item_d.gray   = (chroma == '0);
		item_d.vmax   = vmax;
		item_d.chroma = chroma;
		item_d.hden   = (HX_W'(chroma) << 2) + (HX_W'(chroma) << 1);
		item_d.neg    = 1'b0;
		unique case (sector)
			SEC_RED: begin
				// Only this sector can go negative: green below blue.
				item_d.neg  = (g < b);
				item_d.hnum = (g < b) ? HX_W'(b - g) : HX_W'(g - b);
			end
			SEC_GREEN: begin
				item_d.hnum = HX_W'(b) + (HX_W'(chroma) << 1) - HX_W'(r);
			end
			SEC_BLUE: begin
				item_d.hnum = HX_W'(r) + (HX_W'(chroma) << 2) - HX_W'(g);
			end
			default: begin
				item_d.hnum = '0;
			end
		endcase
	end

	assign pix_stall = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pix_stall && pix_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/rgbhsv_queue.sv @@
// Short FIFO of classified pixels between the front end and the dividers.
// Uses rgbhsv_pkg for the entry type.
`default_nettype none

module rgbhsv_queue #(
	parameter int DEPTH = rgbhsv_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  rgbhsv_pkg::item_t  wr_item,
	input  wire                pop,
	output rgbhsv_pkg::item_t  head,
	output logic               full,
	output logic               empty
);
	import rgbhsv_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/rgbhsv_back.sv @@
// Back end of the RGB to HSV converter: two restoring dividers, one quotient
// bit per stage, and the output register. Uses rgbhsv_pkg.
`default_nettype none

module rgbhsv_back #(
	parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_empty,
	input  rgbhsv_pkg::item_t            head,
	output logic                         pop,
	output logic                         hsv_valid,
	input  wire                          hsv_stall,
	output logic [rgbhsv_pkg::CH_W-1:0]  hue,
	output logic [rgbhsv_pkg::CH_W-1:0]  saturation,
	output logic [rgbhsv_pkg::CH_W-1:0]  brightness
);
	import rgbhsv_pkg::*;

	localparam int QB  = FRACTION_BITS + 1;
	localparam int SRW = CH_W + 1;
	localparam int HRW = HX_W + 1;
	localparam int OW  = (QB > CH_W) ? QB : CH_W;
	localparam logic [QB-1:0] ONE_Q = QB'(1) << FRACTION_BITS;

	// Stage registers, indexed by the quotient step they hold the result of.
	logic            valid_sk [QB];
	logic            gray_sk  [QB];
	logic            neg_sk   [QB];
	logic [CH_W-1:0] sden_sk  [QB];
	logic [HX_W-1:0] hden_sk  [QB];
	logic [SRW-1:0]  srem_sk  [QB];
	logic [HRW-1:0]  hrem_sk  [QB];
	logic [QB-1:0]   squo_sk  [QB];
	logic [QB-1:0]   hquo_sk  [QB];

	logic            hsv_valid_q;
	logic [CH_W-1:0] hue_q, saturation_q, brightness_q;
	logic            en;

	// The whole pipeline moves together whenever the output slot is free.
	assign en  = !hsv_valid_q || !hsv_stall;
	assign pop = en && !q_empty;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [SRW-1:0]  srem_in, srem_out;
		logic [HRW-1:0]  hrem_in, hrem_out;
		logic [QB-1:0]   squo_in, hquo_in;
		logic [CH_W-1:0] sden;
		logic [HX_W-1:0] hden;
		logic            sbit, hbit, vin, gin, nin;

		if (k == 0) begin : g_first
			// First step yields the integer bit: dividend never exceeds divisor.
			assign srem_in = SRW'(head.chroma);
			assign hrem_in = HRW'(head.hnum);
			assign squo_in = '0;
			assign hquo_in = '0;
			assign sden    = head.vmax;
			assign hden    = head.hden;
			assign vin     = !q_empty;
			assign gin     = head.gray;
			assign nin     = head.neg;
		end else begin : g_next
			assign srem_in = srem_sk[k-1] << 1;
			assign hrem_in = hrem_sk[k-1] << 1;
			assign squo_in = squo_sk[k-1];
			assign hquo_in = hquo_sk[k-1];
			assign sden    = sden_sk[k-1];
			assign hden    = hden_sk[k-1];
			assign vin     = valid_sk[k-1];
			assign gin     = gray_sk[k-1];
			assign nin     = neg_sk[k-1];
		end

		assign sbit     = (srem_in >= SRW'(sden));
		assign srem_out = sbit ? srem_in - SRW'(sden) : srem_in;
		assign hbit     = (hrem_in >= HRW'(hden));
		assign hrem_out = hbit ? hrem_in - HRW'(hden) : hrem_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k] <= 1'b0;
			end else if (en) begin
				valid_sk[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				gray_sk[k] <= gin;
				neg_sk[k]  <= nin;
				sden_sk[k] <= sden;
				hden_sk[k] <= hden;
				srem_sk[k] <= srem_out;
				hrem_sk[k] <= hrem_out;
				squo_sk[k] <= {squo_in[QB-2:0], sbit};
				hquo_sk[k] <= {hquo_in[QB-2:0], hbit};
			end
		end
	end

	logic [QB-1:0] hue_full, sat_full;
	logic [OW-1:0] hue_ext, sat_ext;

	always_comb begin
		// Gray pixels (black included) get zero hue and zero saturation.
		if (gray_sk[QB-1]) begin
			hue_full = '0;
			sat_full = '0;
		end else begin
			hue_full = neg_sk[QB-1] ? ONE_Q - hquo_sk[QB-1] : hquo_sk[QB-1];
			sat_full = squo_sk[QB-1];
		end
		hue_ext = OW'(hue_full);
		sat_ext = OW'(sat_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (en) begin
			hsv_valid_q <= valid_sk[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q        <= hue_ext[CH_W-1:0];
			saturation_q <= sat_ext[CH_W-1:0];
			brightness_q <= sden_sk[QB-1];
		end
	end

	assign hsv_valid  = hsv_valid_q;
	assign hue        = hue_q;
	assign saturation = saturation_q;
	assign brightness = brightness_q;

endmodule

`default_nettype wire

@@ rtl/rgbhsv_checker.sv @@
// Port-level checks for the RGB to HSV converter, bound to its top level.
// Uses rgbhsv_pkg for field widths.
`default_nettype none

module rgbhsv_checker #(
	parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          pix_valid,
	input wire                          pix_stall,
	input wire [rgbhsv_pkg::CH_W-1:0]   red,
	input wire [rgbhsv_pkg::CH_W-1:0]   green,
	input wire [rgbhsv_pkg::CH_W-1:0]   blue,
	input wire                          hsv_valid,
	input wire                          hsv_stall,
	input wire [rgbhsv_pkg::CH_W-1:0]   hue,
	input wire [rgbhsv_pkg::CH_W-1:0]   saturation,
	input wire [rgbhsv_pkg::CH_W-1:0]   brightness
);
	import rgbhsv_pkg::*;

	localparam int ONE = 1 << FRACTION_BITS;
	localparam bit FITS = (FRACTION_BITS <= 15);

	// A stalled result beat holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("result beat changed while stalled");

	// Every field stays within one full unit when that unit fits the field.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && FITS |-> (int'(hue) <= ONE) && (int'(saturation) <= ONE)
			&& (int'(brightness) <= ONE))
		else $error("result field above one");

	// Zero saturation means a gray pixel, which has zero hue.
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (saturation == '0) |-> (hue == '0))
		else $error("gray pixel with nonzero hue");

	// A black pixel has zero saturation.
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (brightness == '0) |-> (saturation == '0))
		else $error("black pixel with nonzero saturation");

	// A stalled pixel beat keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("pixel beat changed while stalled");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_rgbhsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_stall  (pix_stall),
	.red        (red),
	.green      (green),
	.blue       (blue),
	.hsv_valid  (hsv_valid),
	.hsv_stall  (hsv_stall),
	.hue        (hue),
	.saturation (saturation),
	.brightness (brightness)
);

`default_nettype wire

@@ verif/rgb_to_hsv_converter_tb.sv @@
// Self-checking testbench for rgb_to_hsv_converter: directed and random RGB pixels.
// Holds its own HSV predictor and a small scoreboard class; depends on rgbhsv_pkg and the RTL.
`default_nettype none

module rgb_to_hsv_converter_tb;

	import rgbhsv_pkg::*;

	// The block runs at its default number of fraction bits, so 1.0 is 1 << 15.
	localparam int  FB      = FRACTION_BITS_DEF;
	localparam longint ONE  = longint'(1) << FB;
	// Time after the last expected beat during which nothing more may appear.
	localparam int  DRAIN_CYCLES = 4 * (FB + 3);
	localparam int  RANDOM_PIXELS = 2000;

	// One HSV beat, either predicted or observed.
	typedef struct {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
	} hsv_t;

	// The scoreboard predicts an HSV beat for every accepted pixel and compares
	// observed beats against the oldest prediction still waiting.
	class hsv_scoreboard;
		hsv_t hsv_expected[$];
		int   errors;
		int   n_checked;
		int   n_gray;
		int   n_black;
		int   n_full_turn;
		int   n_clamped;

		function new();
			errors = 0;
			n_checked = 0;
			n_gray = 0;
			n_black = 0;
			n_full_turn = 0;
			n_clamped = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		function longint clamp_channel(input logic [CH_W-1:0] raw);
			if (longint'(raw) > ONE) begin
				n_clamped++;
				return ONE;
			end
			return longint'(raw);
		endfunction

		// Six-sector hexcone hue with truncated quotients.
		function hsv_t predict_hsv(input logic [CH_W-1:0] r_raw, g_raw, b_raw);
			longint r, g, b, vmax, vmin, chroma, diff, offset, num, den, hue_l, sat_l;
			hsv_t res;
			r = clamp_channel(r_raw);
			g = clamp_channel(g_raw);
			b = clamp_channel(b_raw);
			vmax = r;
			vmin = r;
			if (g > vmax) vmax = g;
			if (b > vmax) vmax = b;
			if (g < vmin) vmin = g;
			if (b < vmin) vmin = b;
			chroma = vmax - vmin;

			sat_l = 0;
			if (vmax != 0)
				sat_l = (chroma << FB) / vmax;
			else
				n_black++;

			hue_l = 0;
			if (chroma == 0) begin
				n_gray++;
			end else begin
				// Red wins a tie for the maximum, then green.
				if (vmax == r) begin
					diff = g - b;
					offset = 0;
				end else if (vmax == g) begin
					diff = b - r;
					offset = 2;
				end else begin
					diff = r - g;
					offset = 4;
				end
				num = (diff + offset * chroma) * ONE;
				den = 6 * chroma;
				if (num < 0)
					hue_l = ONE - ((-num) / den);
				else
					hue_l = num / den;
				if (hue_l == ONE)
					n_full_turn++;
			end

			res.hue = hue_l[CH_W-1:0];
			res.sat = sat_l[CH_W-1:0];
			res.val = vmax[CH_W-1:0];
			return res;
		endfunction

		function void note_pixel(input logic [CH_W-1:0] r, g, b);
			hsv_expected.push_back(predict_hsv(r, g, b));
		endfunction

		task check_result(input logic [CH_W-1:0] h, s, v);
			hsv_t exp_hsv;
			if (hsv_expected.size() == 0) begin
				report_mismatch($sformatf("HSV beat with no pixel pending: h=%0d s=%0d v=%0d",
					h, s, v));
			end else begin
				exp_hsv = hsv_expected.pop_front();
				n_checked++;
				if (h !== exp_hsv.hue)
					report_mismatch($sformatf("hue %0d, expected %0d", h, exp_hsv.hue));
				if (s !== exp_hsv.sat)
					report_mismatch($sformatf("saturation %0d, expected %0d", s, exp_hsv.sat));
				if (v !== exp_hsv.val)
					report_mismatch($sformatf("brightness %0d, expected %0d", v, exp_hsv.val));
			end
		endtask

		function int pending();
			return hsv_expected.size();
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic            clk        = 1'b0;
	logic            arst_n     = 1'b0;
	logic            pix_valid  = 1'b0;
	logic [CH_W-1:0] red        = '0;
	logic [CH_W-1:0] green      = '0;
	logic [CH_W-1:0] blue       = '0;
	logic            hsv_stall  = 1'b0;
	logic            pix_stall;
	logic            hsv_valid;
	logic [CH_W-1:0] hue;
	logic [CH_W-1:0] saturation;
	logic [CH_W-1:0] brightness;

	hsv_scoreboard sb = new();

	// Sender burst bookkeeping: beats left in the current burst.
	int burst_left = 0;

	// Receiver stall pattern: a mode held for a random number of cycles.
	int stall_mode = 0;
	int stall_left = 0;

	rgb_to_hsv_converter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always #5 clk = ~clk;

	// Sends one pixel beat. The task starts and ends on a rising edge. When a
	// burst runs out, valid drops for a random gap while the payload carries
	// junk, then a new burst of random length begins. Often there is no gap
	// at all, and some bursts are long, so there are stretches with no idling.
	task automatic drive_pixel(input logic [CH_W-1:0] r, g, b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				red       <= CH_W'($urandom);
				green     <= CH_W'($urandom);
				blue      <= CH_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		// The payload holds until an edge sees valid high and stall low.
		do
			@(posedge clk);
		while (pix_stall);
		sb.note_pixel(r, g, b);
	endtask

	// Receiver: checks each accepted HSV beat, then picks the next stall value.
	// Outputs are read right at the edge, before any update from that edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hsv_valid && !hsv_stall)
				sb.check_result(hue, saturation, brightness);
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(32, 400);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: hsv_stall <= 1'b0;
				1: hsv_stall <= ($urandom_range(0, 3) == 0);
				2: hsv_stall <= ($urandom_range(0, 3) != 0);
				default: hsv_stall <= stall_left[3];
			endcase
		end
	end

	// Main stimulus: reset, directed corner pixels, then random pixels.
	initial begin
		logic [CH_W-1:0] r, g, b;
		logic [CH_W-1:0] base;
		int kind;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Black, white and a mid gray: gray pixels must give hue 0.
		drive_pixel(16'h0000, 16'h0000, 16'h0000);
		drive_pixel(16'h8000, 16'h8000, 16'h8000);
		drive_pixel(16'd12345, 16'd12345, 16'd12345);
		// Pure primaries, one per hue sector.
		drive_pixel(16'h8000, 16'h0000, 16'h0000);
		drive_pixel(16'h0000, 16'h8000, 16'h0000);
		drive_pixel(16'h0000, 16'h0000, 16'h8000);
		// Ties for the maximum: red beats green and blue, green beats blue.
		drive_pixel(16'h8000, 16'h8000, 16'h0000);
		drive_pixel(16'h8000, 16'h0000, 16'h8000);
		drive_pixel(16'h0000, 16'h8000, 16'h8000);
		// A tiny negative numerator truncates to zero, so hue is a full turn; a tiny positive one gives hue 0.
		drive_pixel(16'h8000, 16'h0000, 16'h0001);
		drive_pixel(16'h8000, 16'h0001, 16'h0000);
		// Negative red-sector hue and ordinary green and blue sectors.
		drive_pixel(16'd30000, 16'd5000, 16'd10000);
		drive_pixel(16'd10000, 16'd30000, 16'd5000);
		drive_pixel(16'd20000, 16'd10000, 16'd30000);
		// Smallest nonzero channels.
		drive_pixel(16'h0001, 16'h0000, 16'h0000);
		drive_pixel(16'h0000, 16'h0001, 16'h0000);
		drive_pixel(16'h0000, 16'h0000, 16'h0001);
		// Channels above 1.0 are clamped first.
		drive_pixel(16'hFFFF, 16'h8001, 16'h0000);
		drive_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		drive_pixel(16'h0000, 16'hC000, 16'h7FFF);
		// Just below 1.0 and odd thirds.
		drive_pixel(16'h7FFF, 16'h5555, 16'h2AAA);
		drive_pixel(16'h7FFF, 16'h7FFF, 16'h7FFE);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				// Raw 16-bit words, so every bit toggles and clamping is exercised.
				6: begin
					r = CH_W'($urandom);
					g = CH_W'($urandom);
					b = CH_W'($urandom);
				end
				// Near gray: small chroma stresses the hue division.
				7: begin
					base = CH_W'($urandom_range(0, 32'(ONE - 8)));
					r = base + CH_W'($urandom_range(0, 3));
					g = base + CH_W'($urandom_range(0, 3));
					b = base + CH_W'($urandom_range(0, 3));
				end
				// Two channels are equal, which gives ties when they hold the maximum.
				8: begin
					base = CH_W'($urandom_range(0, 32'(ONE)));
					r = base;
					g = base;
					b = CH_W'($urandom_range(0, 32'(ONE)));
					if ($urandom_range(0, 1) == 0) begin
						g = b;
						b = base;
					end
					if ($urandom_range(0, 1) == 0) begin
						base = r;
						r = g;
						g = base;
					end
				end
				// Red at the top with green at or just below blue: hues at zero or near a full turn.
				9: begin
					r = CH_W'($urandom_range(32'(ONE - 64), 32'(ONE)));
					g = CH_W'($urandom_range(0, 16));
					b = g + CH_W'($urandom_range(0, 4));
				end
				default: begin
					r = CH_W'($urandom_range(0, 32'(ONE)));
					g = CH_W'($urandom_range(0, 32'(ONE)));
					b = CH_W'($urandom_range(0, 32'(ONE)));
				end
			endcase
			drive_pixel(r, g, b);
		end
		pix_valid <= 1'b0;

		// Drain: wait for every predicted beat, then watch for strays.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d HSV beats under random bursts and output stalls.", sb.n_checked);
		$display("Seen: %0d gray, %0d black, %0d full-turn hues, %0d clamped channels.",
			sb.n_gray, sb.n_black, sb.n_full_turn, sb.n_clamped);
		if (sb.errors == 0) begin
			$display("** rgb_to_hsv_converter: PASSED **");
		end else begin
			$display("** rgb_to_hsv_converter: FAILED **");
		end
		$finish;
	end

	// Watchdog: far longer than the slowest correct run could take.
	initial begin
		#3000000;
		$display("Timeout with %0d HSV beats still pending.", sb.pending());
		$display("** rgb_to_hsv_converter: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
